FILE: rtl/core/route_table_with_ttl_aging_top_assert.svh
// assertion macros for the route table
`ifndef ROUTE_TABLE_WITH_TTL_AGING_TOP_ASSERT_SVH
`define ROUTE_TABLE_WITH_TTL_AGING_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RT_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define RT_ASSERT_IMPL(label, clk, rst, prop, msg)
`define RT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/core/rtta_pkg.sv
`default_nettype none
package rtta_pkg;
   localparam int unsigned Entries = 16;
   localparam int unsigned Metrics = 4;
   localparam int unsigned IdxW = $clog2(Entries);
   localparam int unsigned MslW = (Metrics > 1) ? $clog2(Metrics) : 1;
   localparam int unsigned MetW = $clog2(Entries * Metrics);
   localparam logic [15:0] NoRoute = 16'hffff;

   typedef enum logic [2:0] {
      CMD_SET = 3'd0, CMD_CLEAR = 3'd1, CMD_GET_HOP = 3'd2, CMD_MET_WR = 3'd3,
      CMD_MET_RD = 3'd4, CMD_NEXT_VALID = 3'd5, CMD_DST_AT = 3'd6, CMD_NONE = 3'd7
   } cmd_type;

   typedef struct packed {
      logic [2:0]        cmd;
      logic [15:0]       destination;
      logic [15:0]       hop;
      logic [15:0]       lifetime_secs;
      logic [15:0]       elapsed_secs;
      logic [7:0]        metric_slot;
      logic signed [7:0] metric_in;
      logic [7:0]        position;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [15:0]       route_hop;
      logic signed [7:0] metric_out;
      logic [5:0]        entry_index;
      logic [15:0]       entry_destination;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_APPLY, ST_MREAD, ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request, start scan at index 0 / position
      logic step;      // process entry at scan index, advance
      logic apply;     // commit result of scan
      logic mread;     // capture metric memory read data
      logic send;      // response taken
   } cmd_bus_type;

   // datapath to controller
   typedef struct packed {
      logic last;      // scan index is final entry
      logic skip_scan; // command needs no scan, or no further scan
      logic is_mread;  // command reads metric memory
   } sts_bus_type;
endpackage
`default_nettype wire

FILE: rtl/core/route_table_with_ttl_aging_top.sv
// sequence: after accept, commands that match or age step the table one entry
// per cycle (up to 16 entries), then a commit state before the response
// flow: one item at a time, the next request is taken after the response is sent
// reset: synchronous active high, empties all entries, metrics read as -1
`default_nettype none
module route_table_with_ttl_aging_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rtta_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rtta_pkg::rsp_type      rsp_data
);
   rtta_pkg::cmd_bus_type cmd;
   rtta_pkg::sts_bus_type sts;

   rtta_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .sts, .cmd
   );

   rtta_dpath u_dpath (
      .clock, .reset, .req_data, .rsp_data, .cmd, .sts
   );
endmodule
`default_nettype wire

FILE: rtl/core/rtta_ctrl.sv
`default_nettype none
`include "route_table_with_ttl_aging_top_assert.svh"
module rtta_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire rtta_pkg::sts_bus_type sts,
   output rtta_pkg::cmd_bus_type     cmd
);
   rtta_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= rtta_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         rtta_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = rtta_pkg::ST_SCAN;
            end
         end
         rtta_pkg::ST_SCAN: begin
            if (sts.skip_scan) state_in = rtta_pkg::ST_APPLY;
            else begin
               cmd.step = 1'b1;
               if (sts.last) state_in = rtta_pkg::ST_APPLY;
            end
         end
         rtta_pkg::ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in = sts.is_mread ? rtta_pkg::ST_MREAD : rtta_pkg::ST_DONE;
         end
         rtta_pkg::ST_MREAD: begin
            cmd.mread = 1'b1;
            state_in = rtta_pkg::ST_DONE;
         end
         rtta_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.send = 1'b1;
               state_in = rtta_pkg::ST_IDLE;
            end
         end
         default: state_in = rtta_pkg::ST_IDLE;
      endcase
   end

   `RT_ASSERT_IMPL(a_no_overlap, clock, reset, !(req_ready && rsp_valid), "ready during response")
   `RT_ASSERT_NEXT(a_load_scan, clock, reset, cmd.load, state_ff == rtta_pkg::ST_SCAN, "load lost")
   `RT_ASSERT_NEXT(a_send_idle, clock, reset, cmd.send, req_ready, "no return to idle")
endmodule
`default_nettype wire

FILE: rtl/core/rtta_dpath.sv
`default_nettype none
`include "route_table_with_ttl_aging_top_assert.svh"
module rtta_dpath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rtta_pkg::req_type     req_data,
   output rtta_pkg::rsp_type          rsp_data,
   input  wire rtta_pkg::cmd_bus_type cmd,
   output rtta_pkg::sts_bus_type      sts
);
   localparam int unsigned IW = rtta_pkg::IdxW;
   localparam int unsigned CW = IW + 1;
   localparam int unsigned MW = rtta_pkg::MetW;

   logic                valid_ff [rtta_pkg::Entries];
   logic [15:0]         dst_ff   [rtta_pkg::Entries];
   logic [15:0]         hop_ff   [rtta_pkg::Entries];
   logic [15:0]         life_ff  [rtta_pkg::Entries];
   logic [7:0]          met_mem  [rtta_pkg::Entries * rtta_pkg::Metrics];
   logic                met_wr_ff [rtta_pkg::Entries * rtta_pkg::Metrics];

   rtta_pkg::req_type   req_ff;
   logic [CW-1:0]       idx_ff;
   logic                found_ff, free_ok_ff;
   logic [IW-1:0]       hit_ff, free_ff;
   logic [7:0]          mrd_ff;
   logic                mrd_wr_ff;
   rtta_pkg::rsp_type   rsp_ff, rsp_in;

   logic [IW-1:0]       cur;
   logic [15:0]         life_aged;
   logic                freed, dst_eq, slot_ok, pos_ok;
   logic [MW-1:0]       maddr;
   rtta_pkg::cmd_type   op;

   assign op = rtta_pkg::cmd_type'(req_ff.cmd);
   assign cur = idx_ff[IW-1:0];
   assign slot_ok = {24'd0, req_ff.metric_slot} < 32'(rtta_pkg::Metrics);
   assign pos_ok = {24'd0, req_ff.position} < 32'(rtta_pkg::Entries);
   assign maddr = MW'(32'(hit_ff) * 32'(rtta_pkg::Metrics) + 32'(req_ff.metric_slot));
   assign freed = (op == rtta_pkg::CMD_SET) && (life_ff[cur] != 16'd0)
                  && (life_ff[cur] <= req_ff.elapsed_secs);
   assign life_aged = freed ? 16'd0 : ((op == rtta_pkg::CMD_SET && life_ff[cur] != 16'd0)
                      ? life_ff[cur] - req_ff.elapsed_secs : life_ff[cur]);
   assign dst_eq = (freed ? 16'd0 : dst_ff[cur]) == req_ff.destination;

   assign sts.last = (32'(idx_ff) + 32'd1) >= 32'(rtta_pkg::Entries);
   assign sts.skip_scan = (op == rtta_pkg::CMD_DST_AT) || (op == rtta_pkg::CMD_NONE)
                          || ((op == rtta_pkg::CMD_NEXT_VALID) && !pos_ok)
                          || (found_ff && (op != rtta_pkg::CMD_SET));
   assign sts.is_mread = (op == rtta_pkg::CMD_MET_RD);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rtta_pkg::Entries; i++) begin
            valid_ff[i] <= 1'b0;
            dst_ff[i] <= '0;
            hop_ff[i] <= '0;
            life_ff[i] <= '0;
         end
         for (int i = 0; i < rtta_pkg::Entries * rtta_pkg::Metrics; i++) met_wr_ff[i] <= 1'b0;
      end else if (cmd.step) begin
         if (freed) begin
            valid_ff[cur] <= 1'b0;
            dst_ff[cur] <= '0;
            hop_ff[cur] <= '0;
         end
         life_ff[cur] <= life_aged;
      end else if (cmd.apply) begin
         unique case (op)
            rtta_pkg::CMD_SET: begin
               if (found_ff || free_ok_ff) begin
                  valid_ff[found_ff ? hit_ff : free_ff] <= 1'b1;
                  dst_ff[found_ff ? hit_ff : free_ff] <= req_ff.destination;
                  hop_ff[found_ff ? hit_ff : free_ff] <= req_ff.hop;
                  life_ff[found_ff ? hit_ff : free_ff] <= req_ff.lifetime_secs;
               end
            end
            rtta_pkg::CMD_CLEAR: begin
               if (found_ff) begin
                  valid_ff[hit_ff] <= 1'b0;
                  dst_ff[hit_ff] <= '0;
                  hop_ff[hit_ff] <= '0;
                  life_ff[hit_ff] <= '0;
               end
            end
            rtta_pkg::CMD_MET_WR: begin
               if (found_ff && slot_ok) met_wr_ff[maddr] <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // metric store, written and read in clock
   always_ff @(posedge clock) begin
      if (cmd.apply && op == rtta_pkg::CMD_MET_WR && found_ff && slot_ok)
         met_mem[maddr] <= req_ff.metric_in;
      mrd_ff <= met_mem[maddr];
      mrd_wr_ff <= met_wr_ff[maddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
         found_ff <= 1'b0;
         free_ok_ff <= 1'b0;
         hit_ff <= '0;
         free_ff <= '0;
         idx_ff <= (rtta_pkg::cmd_type'(req_data.cmd) == rtta_pkg::CMD_NEXT_VALID)
                   ? CW'(req_data.position) : '0;
      end else if (cmd.step) begin
         idx_ff <= idx_ff + CW'(1);
         priority case (op)
            rtta_pkg::CMD_SET, rtta_pkg::CMD_CLEAR: begin
               if (!found_ff) begin
                  if (dst_eq) begin
                     found_ff <= 1'b1;
                     hit_ff <= cur;
                  end else if (op == rtta_pkg::CMD_SET && life_aged == 16'd0
                               && !free_ok_ff) begin
                     free_ok_ff <= 1'b1;
                     free_ff <= cur;
                  end
               end
            end
            rtta_pkg::CMD_NEXT_VALID: begin
               if (valid_ff[cur]) begin
                  found_ff <= 1'b1;
                  hit_ff <= cur;
               end
            end
            default: begin
               if (valid_ff[cur] && dst_ff[cur] == req_ff.destination) begin
                  found_ff <= 1'b1;
                  hit_ff <= cur;
               end
            end
         endcase
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.apply) begin
         rsp_in = '0;
         rsp_in.status = 1'b1;
         unique case (op)
            rtta_pkg::CMD_SET: rsp_in.status = !(found_ff || free_ok_ff);
            rtta_pkg::CMD_CLEAR: rsp_in.status = !found_ff;
            rtta_pkg::CMD_GET_HOP: begin
               rsp_in.status = !found_ff;
               rsp_in.route_hop = found_ff ? hop_ff[hit_ff] : rtta_pkg::NoRoute;
            end
            rtta_pkg::CMD_MET_WR: rsp_in.status = !(found_ff && slot_ok);
            rtta_pkg::CMD_MET_RD: begin
               rsp_in.status = !(found_ff && slot_ok);
               rsp_in.metric_out = -8'sd1;
            end
            rtta_pkg::CMD_NEXT_VALID: begin
               rsp_in.status = !found_ff;
               rsp_in.entry_index = found_ff ? 6'(hit_ff) : 6'd0;
            end
            rtta_pkg::CMD_DST_AT: begin
               rsp_in.status = !pos_ok;
               rsp_in.entry_destination = pos_ok ? dst_ff[IW'(req_ff.position)] : 16'd0;
            end
            default: ;
         endcase
      end else if (cmd.mread) begin
         if (found_ff && slot_ok && mrd_wr_ff) rsp_in.metric_out = mrd_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   `RT_ASSERT_NEXT(a_step_adv, clock, reset, cmd.step && !cmd.load, idx_ff == $past(idx_ff) + CW'(1), "scan index")
   `RT_ASSERT_IMPL(a_cmd_excl, clock, reset, $onehot0({cmd.load, cmd.step, cmd.apply, cmd.mread, cmd.send}), "commands overlap")
   `RT_ASSERT_IMPL(a_step_range, clock, reset, !cmd.step || (32'(idx_ff) < 32'(rtta_pkg::Entries)), "scan out of range")
endmodule
`default_nettype wire
